// ===== hdl/pdlbq_pkg.sv =====
// Shared types and constants for the packet delay, loss and burst queue.
// Used by the controller, the datapath and the top level. No dependencies.
package pdlbq_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned TicksPerMsDef = 10;

  localparam int unsigned HandleW  = 16;
  localparam int unsigned DrawW    = 16;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ThrW     = 17;
  localparam int unsigned LimW     = 7;
  localparam int unsigned DelayW   = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [DelayW-1:0] DelayMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DELAY   = 2'd0,
    CFG_MAX_DELAY   = 2'd1,
    CFG_LOSS_THR    = 2'd2,
    CFG_QUEUE_LIMIT = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the accepted item
    logic eval;      // admit/keep decision, queue write, delay product
    logic mul;       // scale the delay in ms to ticks
    logic ld_delay;  // load the saturated tick count
    logic rd;        // read the queue head
    logic load;      // move the read entry into the output register
    logic dec;       // end of tick countdown
  } pdlbq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reload;    // kept packet found the counter expired
    logic flush;     // counter expired and queue not empty
    logic last_one;  // exactly one packet held
    logic out_free;  // output register can take an item this cycle
    logic empty;     // queue is empty
  } pdlbq_sts_t;

endpackage

// ===== hdl/pdlbq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdlbq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pdlbq_ctrl.sv =====
// Controller state machine: sequences one tick through decision, delay
// reload, burst release and countdown. Depends on pdlbq_pkg.
module pdlbq_ctrl import pdlbq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pdlbq_sts_t sts_i,
  output pdlbq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MUL, S_SAT, S_CHECK, S_READ, S_LOAD, S_DEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.reload ? S_MUL : S_CHECK;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SAT;
      end
      S_SAT: begin
        cmd_o.ld_delay = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        state_d = sts_i.flush ? S_READ : S_DEC;
      end
      S_READ: begin
        // Only start a read once the output register is sure to be free.
        if (sts_i.out_free) begin
          cmd_o.rd = 1'b1;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.last_one ? S_DEC : S_READ;
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== hdl/pdlbq_dp.sv =====
// Datapath: configuration registers, queue pointers and count, delay counter,
// delay arithmetic and output register. Depends on pdlbq_pkg and pdlbq_ram.
module pdlbq_dp import pdlbq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned TICKS_PER_MS = TicksPerMsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                pkt_valid_i,
  input  logic [HandleW-1:0]  pkt_handle_i,
  input  logic [DrawW-1:0]    loss_draw_i,
  input  logic [DrawW-1:0]    delay_draw_i,
  input  pdlbq_cmd_t          cmd_i,
  output pdlbq_sts_t          sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HandleW-1:0]  out_handle_o,
  output logic                out_last_o
);

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TpmW  = $clog2(TICKS_PER_MS + 1);
  localparam int unsigned SpanW = MsW + 1;
  localparam int unsigned ProdW = SpanW + DrawW;
  localparam int unsigned TkW   = SpanW + TpmW;
  localparam int unsigned ExtW  = (TkW > DelayW) ? TkW : DelayW;

  // Configuration registers.
  logic [MsW-1:0]  min_q, max_q;
  logic [ThrW-1:0] thr_q;
  logic [LimW-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      thr_q <= '0;
      lim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DELAY:   min_q <= cfg_wdata_i[MsW-1:0];
        CFG_MAX_DELAY:   max_q <= cfg_wdata_i[MsW-1:0];
        CFG_LOSS_THR:    thr_q <= cfg_wdata_i[ThrW-1:0];
        CFG_QUEUE_LIMIT: lim_q <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic               pv_q;
  logic [HandleW-1:0] handle_q;
  logic [DrawW-1:0]   loss_q, ddraw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (cmd_i.capture) begin
      pv_q <= pkt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      handle_q <= pkt_handle_i;
      loss_q   <= loss_draw_i;
      ddraw_q  <= delay_draw_i;
    end
  end

  // Queue state and delay counter.
  logic [PtrW-1:0]   head_q, tail_q;
  logic [CntW-1:0]   cnt_q;
  logic [DelayW-1:0] delay_q, delay_d;

  logic [LimW-1:0]  lim_eff;
  logic             keep, expired;
  logic [SpanW-1:0] span, ms;
  logic [ProdW-1:0] prod_q;
  logic [TkW-1:0]   ticks_q;
  logic [ExtW-1:0]  ticks_ext;
  logic             wr_en;
  logic [HandleW-1:0] ram_rdata;

  assign lim_eff = (lim_q == '0 || lim_q > LimW'(QUEUE_DEPTH)) ? LimW'(QUEUE_DEPTH) : lim_q;
  assign keep    = pv_q && (LimW'(cnt_q) < lim_eff) && ({1'b0, loss_q} >= thr_q);
  assign expired = (delay_q <= DelayW'(1));
  assign wr_en   = cmd_i.eval && keep;

  // A maximum below the minimum collapses the range to the minimum alone.
  assign span = (max_q >= min_q) ? (SpanW'(max_q) - SpanW'(min_q) + SpanW'(1)) : SpanW'(1);
  assign ms   = SpanW'(min_q) + prod_q[DrawW +: SpanW];
  assign ticks_ext = ExtW'(ticks_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      prod_q <= ProdW'(span) * ProdW'(ddraw_q);
    end
    if (cmd_i.mul) begin
      ticks_q <= TkW'(ms) * TkW'(TICKS_PER_MS);
    end
  end

  always_comb begin
    delay_d = delay_q;
    if (cmd_i.ld_delay) begin
      delay_d = (ticks_ext > ExtW'(DelayMax)) ? DelayMax : ticks_ext[DelayW-1:0];
    end else if (cmd_i.dec && !expired) begin
      delay_d = delay_q - DelayW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      delay_q <= '0;
    end else begin
      delay_q <= delay_d;
      if (wr_en) begin
        tail_q <= (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
        cnt_q  <= cnt_q + CntW'(1);
      end else if (cmd_i.load) begin
        head_q <= (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
        cnt_q  <= cnt_q - CntW'(1);
      end
    end
  end

  pdlbq_ram #(
    .WIDTH (HandleW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (handle_q),
    .re_i    (cmd_i.rd),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Output register.
  logic               out_valid_q;
  logic [HandleW-1:0] out_handle_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_handle_q <= ram_rdata;
      out_last_q   <= (cnt_q == CntW'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_handle_o = out_handle_q;
  assign out_last_o   = out_last_q;

  assign sts_o.reload   = keep && expired;
  assign sts_o.flush    = expired && (cnt_q != '0);
  assign sts_o.last_one = (cnt_q == CntW'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.empty    = (cnt_q == '0);

endmodule

// ===== hdl/packet_delay_loss_burst_queue_unit.sv =====
// Packet delay, loss and burst queue: each input item is one 0.1 ms tick that may carry a
// packet handle plus a loss draw and a delay draw. Kept packets wait in a queue until the
// hold delay expires, then the whole queue is released oldest first with tlast on the final
// packet. Each accepted item goes through the decision, a delay reload if a kept packet
// finds the counter expired (scale to ticks, then saturate and load), the release of each
// queued packet, paced by the registered memory read and any stall on the master side,
// then the countdown before the next is taken. No clearing pass is needed after reset.
// Depends on pdlbq_pkg, pdlbq_ctrl, pdlbq_dp and pdlbq_ram.
module packet_delay_loss_burst_queue_unit import pdlbq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned TICKS_PER_MS = TicksPerMsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // packet_handle, loss_draw, delay_draw
  input  logic                s_axis_tuser,  // packet_valid
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // out_handle
  output logic                m_axis_tlast
);

  pdlbq_cmd_t cmd;
  pdlbq_sts_t sts;

  pdlbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdlbq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pkt_valid_i  (s_axis_tuser),
    .pkt_handle_i (s_axis_tdata[15:0]),
    .loss_draw_i  (s_axis_tdata[31:16]),
    .delay_draw_i (s_axis_tdata[47:32]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_handle_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // The block works on one tick at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while a tick is in progress");

  // A new result must never overwrite one still waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !m_axis_tvalid)
    else $error("output register overwritten");

  // The marked item of a burst leaves the queue empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && sts.last_one) |=> (m_axis_tlast && sts.empty))
    else $error("final item of a burst not marked or packets remain queued");

  // A burst is only started when something is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |-> !sts.empty)
    else $error("queue read while empty");

endmodule

// ===== verif/packet_delay_loss_burst_queue_unit_tb.sv =====
// Self-checking testbench for the packet delay, loss and burst queue unit.
// Depends on pdlbq_pkg and packet_delay_loss_burst_queue_unit; a scoreboard class
// predicts each released burst from the accepted ticks and checks the master side.
`timescale 1ns / 100ps

module packet_delay_loss_burst_queue_unit_tb;
  import pdlbq_pkg::*;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic               last;
  } release_t;

  typedef enum int {
    PH_SHORT,
    PH_FILL,
    PH_WIDE,
    PH_SHUT
  } phase_kind_e;

  // Tracks what the queue holds and the bursts that must come out of it.
  class release_tracker;
    logic [MsW-1:0]     min_ms;
    logic [MsW-1:0]     max_ms;
    logic [ThrW-1:0]    loss_thr;
    logic [LimW-1:0]    hold_limit;
    logic [DelayW-1:0]  countdown;
    logic [HandleW-1:0] held[$];
    release_t           due[$];
    int unsigned        faults;

    function new();
      min_ms     = '0;
      max_ms     = '0;
      loss_thr   = '0;
      hold_limit = '0;
      countdown  = '0;
      faults     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_MIN_DELAY:   min_ms     = val[MsW-1:0];
        CFG_MAX_DELAY:   max_ms     = val[MsW-1:0];
        CFG_LOSS_THR:    loss_thr   = val[ThrW-1:0];
        CFG_QUEUE_LIMIT: hold_limit = val[LimW-1:0];
        default: ;
      endcase
    endfunction

    function logic [DelayW-1:0] hold_ticks(logic [DrawW-1:0] draw);
      logic [16:0] span;
      logic [32:0] prod;
      logic [31:0] ms;
      logic [35:0] ticks;
      // A maximum below the minimum collapses the range to the minimum alone.
      span  = (max_ms >= min_ms) ? 17'(max_ms - min_ms) + 17'd1 : 17'd1;
      prod  = 33'(span) * 33'(draw);
      ms    = 32'(min_ms) + 32'(prod >> 16);
      ticks = 36'(ms) * 36'(TicksPerMsDef);
      return (ticks > 36'(DelayMax)) ? DelayMax : ticks[DelayW-1:0];
    endfunction

    function void note_tick(bit pv, logic [HandleW-1:0] h, logic [DrawW-1:0] l,
                            logic [DrawW-1:0] d);
      int unsigned cap;
      release_t    r;
      cap = (hold_limit == 0 || hold_limit > QueueDepthDef) ? QueueDepthDef : hold_limit;
      if (pv && held.size() < cap && ThrW'(l) >= loss_thr) begin
        held = {held, h};
        if (countdown <= 1) countdown = hold_ticks(d);
      end
      if (countdown <= 1) begin
        while (held.size() > 0) begin
          r.handle = held[0];
          held.delete(0);
          r.last   = (held.size() == 0);
          due = {due, r};
        end
      end
      if (countdown > 1) countdown--;
    endfunction

    function void check_release(logic [HandleW-1:0] h, logic last);
      release_t exp_r;
      if (due.size() == 0) begin
        $error("unexpected item: out_handle %h out_last %b", h, last);
        faults++;
        return;
      end
      exp_r = due[0];
      due.delete(0);
      if (h !== exp_r.handle) begin
        $error("out_handle: expected %h, actual %h", exp_r.handle, h);
        faults++;
      end
      if (last !== exp_r.last) begin
        $error("out_last: expected %b, actual %b", exp_r.last, last);
        faults++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata;   // packet_handle, loss_draw, delay_draw
  logic                s_axis_tuser;   // packet_valid
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // out_handle
  logic                m_axis_tlast;

  release_tracker sb;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  int unsigned    items_sent = 0;

  packet_delay_loss_burst_queue_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_release(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high, so that a
  // following item can go out without a gap.
  task automatic send_tick(input bit pv, input logic [15:0] h, input logic [15:0] l,
                           input logic [15:0] d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= pv;
    s_axis_tdata  <= {d, l, h};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(pv, h, l, d);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and let the block drain; a tick with no release may still be in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    sb.write_reg(idx, CfgDataW'(val));
    @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned mn, input int unsigned mx,
                            input int unsigned thr, input int unsigned lim);
    cfg_write(CFG_MIN_DELAY, mn);
    cfg_write(CFG_MAX_DELAY, mx);
    cfg_write(CFG_LOSS_THR, thr);
    cfg_write(CFG_QUEUE_LIMIT, lim);
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_idling();
    if (items_sent < 120) begin
      tx_idle_pct = 21;
      rx_idle_pct = 68;
    end else if (items_sent < 240) begin
      tx_idle_pct = 68;
      rx_idle_pct = 21;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  task automatic run_phase(input phase_kind_e kind);
    int unsigned n;
    int unsigned lim;
    bit          pv;
    logic [15:0] h;
    logic [15:0] l;
    logic [15:0] d;
    lim = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(0, 127);
    case (kind)
      PH_SHORT: begin
        set_config($urandom_range(0, 3), $urandom_range(0, 4),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40000), lim);
        n = $urandom_range(30, 50);
      end
      PH_FILL: begin
        // A long hold lets the queue reach full depth before the burst goes out.
        set_config(8, 8, 0, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(64, 127));
        n = 90;
      end
      PH_WIDE: begin
        set_config(0, 65535, $urandom_range(0, 30000), lim);
        n = $urandom_range(30, 50);
      end
      default: begin
        // Everything is dropped, so the huge minimum never loads the counter.
        set_config(65535, $urandom_range(0, 65535), 65536, lim);
        n = 10;
      end
    endcase
    pick_idling();
    for (int i = 0; i < n; i++) begin
      pv = ($urandom_range(0, 99) < 85);
      h  = 16'($urandom);
      l  = 16'($urandom);
      d  = 16'($urandom);
      // Over the full range only tiny draws keep the hold short.
      if (kind == PH_WIDE) d = 16'($urandom_range(0, 3));
      send_tick(pv, h, l, d);
    end
    settle();
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MIN_DELAY;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero delay and zero threshold: every packet is kept and leaves at once.
    set_config(0, 0, 0, 0);
    send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_tick(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000);
    settle();

    // Maximum below minimum gives a 1 ms hold; the limit of 3 fills the queue, and draws
    // just below the threshold are dropped.
    set_config(1, 0, 16'h8000, 3);
    send_tick(1'b1, 16'h1111, 16'h8000, 16'hFFFF);
    send_tick(1'b1, 16'hBEEF, 16'h7FFF, 16'h0000);
    send_tick(1'b1, 16'h2222, 16'hFFFF, 16'h1234);
    send_tick(1'b1, 16'h3333, 16'h8001, 16'h0000);
    send_tick(1'b1, 16'h4444, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_tick(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    settle();

    // Full-scale threshold drops everything; a limit above the depth acts as the depth.
    set_config(65535, 65535, 65536, 127);
    send_tick(1'b1, 16'h5A5A, 16'hFFFF, 16'h0000);
    send_tick(1'b1, 16'hA5A5, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 16'h0F0F, 16'h0000, 16'h8000);
    settle();

    items_sent = 0;
    run_phase(PH_SHORT);
    run_phase(PH_FILL);
    run_phase(PH_WIDE);
    run_phase(PH_SHUT);
    while (items_sent < 340) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_phase(PH_SHORT);
        6:                run_phase(PH_FILL);
        7:                run_phase(PH_SHUT);
        default:          run_phase(PH_WIDE);
      endcase
    end

    if (sb.faults == 0 && sb.due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pdlbq_pkg.sv
hdl/pdlbq_ram.sv
hdl/pdlbq_ctrl.sv
hdl/pdlbq_dp.sv
hdl/packet_delay_loss_burst_queue_unit.sv
verif/packet_delay_loss_burst_queue_unit_tb.sv
